>>> src/gclk_pkg.sv
// gclk_pkg: shared types, register map and status codes of the game clock
// depends on: nothing
package gclk_pkg;

    // configuration register file contents
    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] increment_time;
        logic [15:0] step_size;
    } t_cfg;

    // register reset values
    localparam logic [31:0] START_TIME_RST = 32'd300000;
    localparam logic [31:0] INCR_TIME_RST  = 32'd0;
    localparam logic [15:0] STEP_SIZE_RST  = 16'd1;

    // register map, one 32-bit word per register
    localparam int          ADDR_W         = 4;
    localparam logic [1:0]  REG_START_TIME = 2'd0;
    localparam logic [1:0]  REG_INCR_TIME  = 2'd1;
    localparam logic [1:0]  REG_STEP_SIZE  = 2'd2;

    // item action codes
    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_START = 1'b1;

    // side to move
    localparam logic MOVER_WHITE = 1'b0;
    localparam logic MOVER_BLACK = 1'b1;

    // status code shown on the result
    typedef enum logic [1:0] {
        STATUS_IDLE      = 2'd0,
        STATUS_RUNNING   = 2'd1,
        STATUS_WHITE_WON = 2'd2,
        STATUS_BLACK_WON = 2'd3
    } t_status;

    // game state machine
    typedef enum logic [3:0] {
        GS_IDLE      = 4'b0001,
        GS_RUNNING   = 4'b0010,
        GS_WHITE_WON = 4'b0100,
        GS_BLACK_WON = 4'b1000
    } t_game_state;

    // state to status code
    function automatic t_status status_code(t_game_state s);
        t_status c;
        unique case (s)
            GS_IDLE:      c = STATUS_IDLE;
            GS_RUNNING:   c = STATUS_RUNNING;
            GS_WHITE_WON: c = STATUS_WHITE_WON;
            GS_BLACK_WON: c = STATUS_BLACK_WON;
            default:      c = STATUS_IDLE;
        endcase
        return c;
    endfunction

endpackage

>>> src/gclk_regs.sv
// gclk_regs: APB-style configuration registers of the game clock
// depends on: gclk_pkg
module gclk_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gclk_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output gclk_pkg::t_cfg              o_cfg
);

    gclk_pkg::t_cfg r_cfg;
    gclk_pkg::t_cfg n_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // register write
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                gclk_pkg::REG_START_TIME: n_cfg.start_time     = pwdata;
                gclk_pkg::REG_INCR_TIME:  n_cfg.increment_time = pwdata;
                gclk_pkg::REG_STEP_SIZE:  n_cfg.step_size      = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_time     <= gclk_pkg::START_TIME_RST;
            r_cfg.increment_time <= gclk_pkg::INCR_TIME_RST;
            r_cfg.step_size      <= gclk_pkg::STEP_SIZE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // register read
    always_comb begin
        unique case (reg_idx)
            gclk_pkg::REG_START_TIME: prdata = r_cfg.start_time;
            gclk_pkg::REG_INCR_TIME:  prdata = r_cfg.increment_time;
            gclk_pkg::REG_STEP_SIZE:  prdata = 32'(r_cfg.step_size);
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/gclk_step.sv
// gclk_step: next game state for one item (start or tick)
// depends on: gclk_pkg
module gclk_step #(
    parameter int TIME_WIDTH = 32
) (
    input  gclk_pkg::t_cfg          i_cfg,
    input  logic                    i_action,
    input  logic                    i_switch_a,
    input  logic                    i_switch_b,
    input  logic [TIME_WIDTH-1:0]   i_white,
    input  logic [TIME_WIDTH-1:0]   i_black,
    input  logic                    i_mover,
    input  logic                    i_last_a,
    input  logic                    i_last_b,
    input  gclk_pkg::t_game_state   i_state,
    output logic [TIME_WIDTH-1:0]   o_white,
    output logic [TIME_WIDTH-1:0]   o_black,
    output logic                    o_mover,
    output logic                    o_last_a,
    output logic                    o_last_b,
    output gclk_pkg::t_game_state   o_state
);

    // working width covers the time and the 32-bit config values plus a carry
    localparam int SW = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 1;
    localparam logic [SW-1:0] SAT_LIM = {{(SW-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

    logic [SW-1:0]         start_ext;
    logic [TIME_WIDTH-1:0] start_t;
    logic                  changed;
    logic                  mover_n;
    logic [TIME_WIDTH-1:0] white_inc;
    logic [TIME_WIDTH-1:0] black_inc;
    logic [TIME_WIDTH-1:0] white_run;
    logic [TIME_WIDTH-1:0] black_run;

    // saturating add of the increment
    function automatic logic [TIME_WIDTH-1:0] sat_add(logic [TIME_WIDTH-1:0] t,
                                                      logic [31:0] inc);
        logic [SW-1:0] sum;
        sum = SW'(t) + SW'(inc);
        return (sum > SAT_LIM) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
    endfunction

    // subtract a step, stopping at zero
    function automatic logic [TIME_WIDTH-1:0] sat_sub(logic [TIME_WIDTH-1:0] t,
                                                      logic [15:0] d);
        return (SW'(d) >= SW'(t)) ? '0 : (t - TIME_WIDTH'(d));
    endfunction

    assign start_ext = SW'(i_cfg.start_time);
    assign start_t   = start_ext[TIME_WIDTH-1:0];

    // tick datapath: pass the move on a switch change, credit, then charge the mover
    assign changed   = (i_switch_a != i_last_a) || (i_switch_b != i_last_b);
    assign mover_n   = i_mover ^ changed;
    assign white_inc = (changed && i_mover == gclk_pkg::MOVER_WHITE)
                       ? sat_add(i_white, i_cfg.increment_time) : i_white;
    assign black_inc = (changed && i_mover == gclk_pkg::MOVER_BLACK)
                       ? sat_add(i_black, i_cfg.increment_time) : i_black;
    assign white_run = (mover_n == gclk_pkg::MOVER_WHITE)
                       ? sat_sub(white_inc, i_cfg.step_size) : white_inc;
    assign black_run = (mover_n == gclk_pkg::MOVER_BLACK)
                       ? sat_sub(black_inc, i_cfg.step_size) : black_inc;

    // select start, running tick, or hold
    always_comb begin
        o_white  = i_white;
        o_black  = i_black;
        o_mover  = i_mover;
        o_last_a = i_last_a;
        o_last_b = i_last_b;
        o_state  = i_state;
        priority if (i_action == gclk_pkg::ACTION_START) begin
            o_white  = start_t;
            o_black  = start_t;
            o_mover  = gclk_pkg::MOVER_WHITE;
            o_last_a = 1'b0;
            o_last_b = 1'b0;
            o_state  = (start_t == '0) ? gclk_pkg::GS_BLACK_WON : gclk_pkg::GS_RUNNING;
        end else if (i_state == gclk_pkg::GS_RUNNING) begin
            o_white  = white_run;
            o_black  = black_run;
            o_mover  = mover_n;
            o_last_a = i_switch_a;
            o_last_b = i_switch_b;
            priority if (white_run == '0) begin
                o_state = gclk_pkg::GS_BLACK_WON;
            end else if (black_run == '0) begin
                o_state = gclk_pkg::GS_WHITE_WON;
            end else begin
                o_state = gclk_pkg::GS_RUNNING;
            end
        end else begin
            // idle or finished: tick is ignored, state holds
        end
    end

endmodule

>>> src/two_player_game_clock_unit.sv
// an accepted item goes through the input register, then the result register, which shows it;
// throughput: one item per cycle while the result is not stalled
// a stalled result holds, one more item waits in the input register, and only then
// is the input stalled
// reset: synchronous, active low; clears valids, both times, mover, switch history and
// game state (idle), and loads the register reset values
module two_player_game_clock_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gclk_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input item channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic                        i_switch_a,
    input  logic                        i_switch_b,
    // result item channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [31:0]                 o_white_time,
    output logic [31:0]                 o_black_time,
    output logic                        o_to_move,
    output logic [1:0]                  o_status
);

    gclk_pkg::t_cfg        cfg;

    logic                  r_in_valid, n_in_valid;
    logic                  r_in_action, r_in_sw_a, r_in_sw_b;
    logic                  r_out_valid, n_out_valid;

    logic [TIME_WIDTH-1:0] r_white, r_black;
    logic                  r_mover, r_last_a, r_last_b;
    gclk_pkg::t_game_state r_state;

    logic [TIME_WIDTH-1:0] n_white, n_black;
    logic                  n_mover, n_last_a, n_last_b;
    gclk_pkg::t_game_state n_state;

    logic                  in_load;
    logic                  advance;

    gclk_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake: the held item moves on when the result register is free or taken
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign in_load     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = in_load ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_action <= i_action;
            r_in_sw_a   <= i_switch_a;
            r_in_sw_b   <= i_switch_b;
        end
    end

    gclk_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_cfg      (cfg),
        .i_action   (r_in_action),
        .i_switch_a (r_in_sw_a),
        .i_switch_b (r_in_sw_b),
        .i_white    (r_white),
        .i_black    (r_black),
        .i_mover    (r_mover),
        .i_last_a   (r_last_a),
        .i_last_b   (r_last_b),
        .i_state    (r_state),
        .o_white    (n_white),
        .o_black    (n_black),
        .o_mover    (n_mover),
        .o_last_a   (n_last_a),
        .o_last_b   (n_last_b),
        .o_state    (n_state)
    );

    // game state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_white     <= '0;
            r_black     <= '0;
            r_mover     <= gclk_pkg::MOVER_WHITE;
            r_last_a    <= 1'b0;
            r_last_b    <= 1'b0;
            r_state     <= gclk_pkg::GS_IDLE;
        end else begin
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_white  <= n_white;
                r_black  <= n_black;
                r_mover  <= n_mover;
                r_last_a <= n_last_a;
                r_last_b <= n_last_b;
                r_state  <= n_state;
            end
        end
    end

    // result fields
    assign o_out_valid  = r_out_valid;
    assign o_white_time = 32'(r_white);
    assign o_black_time = 32'(r_black);
    assign o_to_move    = r_mover;
    assign o_status     = gclk_pkg::status_code(r_state);

endmodule

>>> src/gclk_checker.sv
// gclk_port_checks: port-level checks of the game clock, bound to the top level
// depends on: gclk_pkg, two_player_game_clock_unit
module gclk_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_white_time,
    input logic [31:0] o_black_time,
    input logic        o_to_move,
    input logic [1:0]  o_status
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_white_time)
            && $stable(o_black_time) && $stable(o_to_move) && $stable(o_status))
        else $error("stalled result item changed");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // before any game both clocks read zero with white to move
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == gclk_pkg::STATUS_IDLE
            |-> o_white_time == 32'd0 && o_black_time == 32'd0 && o_to_move == 1'b0)
        else $error("idle result with nonzero state");

    // a finished game shows the loser's clock at zero
    a_loser_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == gclk_pkg::STATUS_BLACK_WON
            || o_status == gclk_pkg::STATUS_WHITE_WON)
            |-> (o_status == gclk_pkg::STATUS_BLACK_WON) ? (o_white_time == 32'd0)
                                                           : (o_black_time == 32'd0))
        else $error("finished game with loser time nonzero");

    // a new item can arrive while the output is free
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_out_valid |-> !o_in_stall)
        else $error("input stalled while result register free");

endmodule

bind two_player_game_clock_unit gclk_port_checks u_gclk_checker (.*);
